>>> rtl/skl_pkg.sv
// Shared types, constants and keyword tables for the SQL keyword lexer.
`timescale 1ns / 1ps
`default_nettype none

package skl_pkg;

    // Token capacity of one expression and the counter width that holds it.
    localparam int MAX_TOKENS = 256;
    localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TOKENS);

    // Command queue between the classifier and the result sequencer.
    localparam int Q_AW        = 2;
    localparam int QUEUE_DEPTH = 1 << Q_AW;

    localparam int NUM_KW = 9;

    // Token codes.
    localparam logic [4:0] TOK_COMMA    = 5'd0;
    localparam logic [4:0] TOK_SEMI     = 5'd1;
    localparam logic [4:0] TOK_STRING   = 5'd3;
    localparam logic [4:0] TOK_SELECT   = 5'd4;
    localparam logic [4:0] TOK_CREATE   = 5'd5;
    localparam logic [4:0] TOK_INSERT   = 5'd6;
    localparam logic [4:0] TOK_INTO     = 5'd7;
    localparam logic [4:0] TOK_UPDATE   = 5'd8;
    localparam logic [4:0] TOK_DROP     = 5'd10;
    localparam logic [4:0] TOK_LPAREN   = 5'd12;
    localparam logic [4:0] TOK_RPAREN   = 5'd13;
    localparam logic [4:0] TOK_STAR     = 5'd14;
    localparam logic [4:0] TOK_FROM     = 5'd15;
    localparam logic [4:0] TOK_DATABASE = 5'd16;
    localparam logic [4:0] TOK_TABLE    = 5'd17;

    // Keyword indexes, in matching priority order.
    localparam logic [3:0] KW_SELECT   = 4'd0;
    localparam logic [3:0] KW_CREATE   = 4'd1;
    localparam logic [3:0] KW_INSERT   = 4'd2;
    localparam logic [3:0] KW_INTO     = 4'd3;
    localparam logic [3:0] KW_UPDATE   = 4'd4;
    localparam logic [3:0] KW_DROP     = 4'd5;
    localparam logic [3:0] KW_DATABASE = 4'd6;
    localparam logic [3:0] KW_FROM     = 4'd7;
    localparam logic [3:0] KW_TABLE    = 4'd8;

    typedef struct packed {
        logic [7:0] ch;
        logic       terminator;
    } t_in_req;

    typedef struct packed {
        logic [4:0] token_code;
        logic [7:0] text_char;
        logic       is_text;
        logic       token_done;
        logic [7:0] token_pos;
        logic [7:0] string_pos;
        logic       overflow;
        logic       last;
    } t_out_req;

    // One classified input item: prefix replay, one text character, string
    // end and a single token, sent in that order.
    typedef struct packed {
        logic [3:0] kw;
        logic [3:0] pre_len;
        logic       txt_en;
        logic [7:0] txt_char;
        logic       str_end;
        logic       str_ovf;
        logic [7:0] str_tpos;
        logic [7:0] str_spos;
        logic       tok_en;
        logic [4:0] tok_code;
        logic       tok_ovf;
        logic [7:0] tok_tpos;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic       found;
        logic [3:0] idx;
    } t_ext;

    // Keyword text, right-justified: the first character is the highest byte in use.
    function automatic logic [63:0] kw_text(input logic [3:0] k);
        logic [63:0] t;
        unique case (k)
            KW_SELECT:   t = 64'("select");
            KW_CREATE:   t = 64'("create");
            KW_INSERT:   t = 64'("insert");
            KW_INTO:     t = 64'("into");
            KW_UPDATE:   t = 64'("update");
            KW_DROP:     t = 64'("drop");
            KW_DATABASE: t = 64'("database");
            KW_FROM:     t = 64'("from");
            KW_TABLE:    t = 64'("table");
            default:     t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] kw_len(input logic [3:0] k);
        logic [3:0] n;
        unique case (k)
            KW_SELECT, KW_CREATE, KW_INSERT, KW_UPDATE: n = 4'd6;
            KW_INTO, KW_DROP, KW_FROM:                  n = 4'd4;
            KW_DATABASE:                                n = 4'd8;
            KW_TABLE:                                   n = 4'd5;
            default:                                    n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [4:0] kw_code(input logic [3:0] k);
        logic [4:0] c;
        unique case (k)
            KW_SELECT:   c = TOK_SELECT;
            KW_CREATE:   c = TOK_CREATE;
            KW_INSERT:   c = TOK_INSERT;
            KW_INTO:     c = TOK_INTO;
            KW_UPDATE:   c = TOK_UPDATE;
            KW_DROP:     c = TOK_DROP;
            KW_DATABASE: c = TOK_DATABASE;
            KW_FROM:     c = TOK_FROM;
            KW_TABLE:    c = TOK_TABLE;
            default:     c = TOK_STRING;
        endcase
        return c;
    endfunction

    // Character i (from the start) of keyword k.
    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] i);
        logic [63:0] t;
        logic [2:0]  b;
        t = kw_text(k);
        b = 3'(kw_len(k) - 4'd1 - {1'b0, i});
        return t[{b, 3'b000} +: 8];
    endfunction

    // Length of the common prefix of two keywords.
    function automatic logic [3:0] kw_lcp(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] n;
        if (a == b) begin
            n = kw_len(a);
        end else if ((a == KW_INSERT && b == KW_INTO) || (a == KW_INTO && b == KW_INSERT)) begin
            n = 4'd2;
        end else if ((a == KW_DROP && b == KW_DATABASE) || (a == KW_DATABASE && b == KW_DROP)) begin
            n = 4'd1;
        end else begin
            n = 4'd0;
        end
        return n;
    endfunction

    // First keyword that shares the matched prefix of keyword k and has c next.
    function automatic t_ext kw_extend(input logic [3:0] k, input logic [3:0] len,
                                       input logic [7:0] c);
        t_ext r;
        r = '0;
        for (int j = NUM_KW - 1; j >= 0; j--) begin
            if (kw_len(4'(j)) > len && kw_lcp(4'(j), k) >= len &&
                kw_char(4'(j), len[2:0]) == c) begin
                r.found = 1'b1;
                r.idx   = 4'(j);
            end
        end
        return r;
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "0" && c <= "9") || c == "_";
    endfunction

    function automatic logic [7:0] cnt_pos(input logic [CNT_W-1:0] v);
        logic [CNT_W+7:0] w;
        w = {8'd0, v};
        return w[7:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/sql_keyword_lexer.sv
// Top level of the SQL keyword lexer: classifier, command queue and sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Streaming lexer for SQL text. Characters arrive as requests on the input
// channel (i_in_valid / o_in_stall); a request with terminator set closes the
// text, flushes any pending keyword prefix or string and clears all state.
// Results leave as requests on the output channel (o_out_valid / i_out_stall),
// one token, string character or string end marker per request, with last set
// on the final result caused by an input character.
// The classifier takes one character per cycle while the queue is not full
// and turns each character that causes a result into a command in a
// four-entry queue; the sequencer sends one result per cycle while the receiver
// does not stall. A character that replays a keyword prefix causes up to ten
// results, and the queue lets the input keep flowing while the sequencer works
// through such a burst. The first result of a character passes through the
// queue and the sequencer's output register before it is visible. When the
// receiver stalls, the output request holds, the queue fills and o_in_stall
// rises once it is full. A synchronous reset (i_rst_n low) empties the queue
// and output register and returns the lexer to its idle state.

module sql_keyword_lexer import skl_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_in_req i_in_data,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_out_req     o_out_data
);

    logic      push;
    logic      pop;
    t_cmd      cmd;
    t_cmd      head;
    t_q_status q_status;

    // The classifier only moves while the queue has room.
    assign o_in_stall = q_status.full;

    skl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_full     (q_status.full),
        .o_push     (push),
        .o_cmd      (cmd)
    );

    skl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (cmd),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    skl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_status    (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> rtl/skl_front.sv
// Classifier: keyword matching, string and count state, command generation.
`timescale 1ns / 1ps
`default_nettype none

module skl_front import skl_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_in_req i_in_data,
    input  wire logic    i_full,
    output logic         o_push,
    output t_cmd         o_cmd
);

    logic [3:0]       r_kw, n_kw;
    logic [3:0]       r_len, n_len;
    logic             r_instr, n_instr;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_tc, n_tc;
    logic [CNT_W-1:0] r_sc, n_sc;

    logic             accept;
    logic [7:0]       c;
    logic             word;
    logic             punct;
    logic [4:0]       pcode;
    t_ext             ext_idle;
    t_ext             ext_cur;
    logic [3:0]       pre_len;
    logic             txt_en;
    logic             str_end;
    logic             tok_en;
    logic [4:0]       tok_code;
    logic             s_ovf;
    logic             t_ovf;
    logic [CNT_W-1:0] tc1;
    logic [CNT_W-1:0] sc1;

    assign accept = i_in_valid && !i_full;

    always_comb begin
        c = i_in_data.ch;
        if (c >= "A" && c <= "Z") begin
            c = i_in_data.ch + 8'd32;
        end
        word  = is_word(c);
        punct = 1'b1;
        pcode = TOK_COMMA;
        unique case (c)
            ",":     pcode = TOK_COMMA;
            "(":     pcode = TOK_LPAREN;
            ")":     pcode = TOK_RPAREN;
            "*":     pcode = TOK_STAR;
            ";":     pcode = TOK_SEMI;
            default: punct = 1'b0;
        endcase
        ext_idle = kw_extend(KW_SELECT, 4'd0, c);
        ext_cur  = kw_extend(r_kw, r_len, c);
    end

    always_comb begin
        n_kw     = r_kw;
        n_len    = r_len;
        n_instr  = r_instr;
        n_done   = r_done;
        pre_len  = 4'd0;
        txt_en   = 1'b0;
        str_end  = 1'b0;
        tok_en   = 1'b0;
        tok_code = pcode;

        if (i_in_data.terminator) begin
            if (r_len != 4'd0) begin
                pre_len = r_len;
                str_end = 1'b1;
            end else if (r_instr) begin
                str_end = 1'b1;
            end
            n_len   = 4'd0;
            n_instr = 1'b0;
            n_done  = 1'b0;
        end else if (!r_done) begin
            if (r_instr) begin
                if (word) begin
                    txt_en = 1'b1;
                end else begin
                    // The string ends here; the character is then taken as if idle.
                    str_end = 1'b1;
                    n_instr = 1'b0;
                    tok_en  = punct;
                    n_done  = punct && pcode == TOK_SEMI;
                end
            end else if (r_len != 4'd0) begin
                if (r_len == kw_len(r_kw) && c == " ") begin
                    tok_en   = 1'b1;
                    tok_code = kw_code(r_kw);
                    n_len    = 4'd0;
                end else if (r_len != kw_len(r_kw) && ext_cur.found) begin
                    n_kw  = ext_cur.idx;
                    n_len = r_len + 4'd1;
                end else begin
                    // No keyword fits: the matched prefix becomes a string.
                    pre_len = r_len;
                    n_len   = 4'd0;
                    if (word) begin
                        txt_en  = 1'b1;
                        n_instr = 1'b1;
                    end else begin
                        str_end = 1'b1;
                        tok_en  = punct;
                        n_done  = punct && pcode == TOK_SEMI;
                    end
                end
            end else begin
                if (punct) begin
                    tok_en = 1'b1;
                    n_done = pcode == TOK_SEMI;
                end else if (ext_idle.found) begin
                    n_kw  = ext_idle.idx;
                    n_len = 4'd1;
                end else if (word) begin
                    txt_en  = 1'b1;
                    n_instr = 1'b1;
                end
            end
        end

        // Counts: a string end takes a slot first, then the token.
        s_ovf = r_tc >= MAX_CNT;
        if (s_ovf) begin
            pre_len = 4'd0;
            txt_en  = 1'b0;
        end
        tc1 = r_tc;
        sc1 = r_sc;
        if (str_end && !s_ovf) begin
            tc1 = r_tc + CNT_W'(1);
            sc1 = r_sc + CNT_W'(1);
        end
        t_ovf = tc1 >= MAX_CNT;
        n_tc  = tc1;
        n_sc  = sc1;
        if (tok_en && !t_ovf) begin
            n_tc = tc1 + CNT_W'(1);
        end
        if (i_in_data.terminator) begin
            n_tc = '0;
            n_sc = '0;
        end

        o_cmd.kw       = r_kw;
        o_cmd.pre_len  = pre_len;
        o_cmd.txt_en   = txt_en;
        o_cmd.txt_char = c;
        o_cmd.str_end  = str_end;
        o_cmd.str_ovf  = s_ovf;
        o_cmd.str_tpos = s_ovf ? 8'd0 : cnt_pos(r_tc);
        o_cmd.str_spos = s_ovf ? 8'd0 : cnt_pos(r_sc);
        o_cmd.tok_en   = tok_en;
        o_cmd.tok_code = tok_code;
        o_cmd.tok_ovf  = t_ovf;
        o_cmd.tok_tpos = t_ovf ? 8'd0 : cnt_pos(tc1);
        o_push = accept && (pre_len != 4'd0 || txt_en || str_end || tok_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw    <= KW_SELECT;
            r_len   <= 4'd0;
            r_instr <= 1'b0;
            r_done  <= 1'b0;
            r_tc    <= '0;
            r_sc    <= '0;
        end else if (accept) begin
            r_kw    <= n_kw;
            r_len   <= n_len;
            r_instr <= n_instr;
            r_done  <= n_done;
            r_tc    <= n_tc;
            r_sc    <= n_sc;
        end
    end

endmodule

`default_nettype wire

>>> rtl/skl_queue.sv
// Short command queue between the classifier and the result sequencer.
`timescale 1ns / 1ps
`default_nettype none

module skl_queue import skl_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = r_cnt == (Q_AW + 1)'(QUEUE_DEPTH);
    assign o_status.empty = r_cnt == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (Q_AW + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (Q_AW + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/skl_back.sv
// Result sequencer: expands one command into results, one per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module skl_back import skl_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd      i_head,
    input  wire t_q_status i_status,
    output logic           o_pop,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_req       o_out_data
);

    logic [3:0] r_pos;
    logic       r_valid;
    t_out_req   r_res;
    t_out_req   res;
    logic [3:0] th_b;
    logic [3:0] th_c;
    logic [3:0] th_d;
    logic       advance;
    logic       is_last;

    assign advance = !r_valid || !i_out_stall;

    always_comb begin
        th_b    = i_head.pre_len + {3'b000, i_head.txt_en};
        th_c    = th_b + {3'b000, i_head.str_end};
        th_d    = th_c + {3'b000, i_head.tok_en};
        is_last = (r_pos + 4'd1) == th_d;

        res.token_code = TOK_STRING;
        res.text_char  = 8'd0;
        res.is_text    = 1'b0;
        res.token_done = 1'b0;
        res.token_pos  = i_head.str_tpos;
        res.string_pos = i_head.str_spos;
        res.overflow   = 1'b0;
        res.last       = is_last;
        if (r_pos < i_head.pre_len) begin
            res.text_char = kw_char(i_head.kw, r_pos[2:0]);
            res.is_text   = 1'b1;
        end else if (r_pos < th_b) begin
            res.text_char = i_head.txt_char;
            res.is_text   = 1'b1;
        end else if (r_pos < th_c) begin
            res.token_done = 1'b1;
            res.overflow   = i_head.str_ovf;
        end else begin
            res.token_code = i_head.tok_code;
            res.token_done = 1'b1;
            res.token_pos  = i_head.tok_tpos;
            res.string_pos = 8'd0;
            res.overflow   = i_head.tok_ovf;
        end
        o_pop = advance && !i_status.empty && is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 4'd0;
        end else if (advance) begin
            r_valid <= !i_status.empty;
            if (!i_status.empty) begin
                r_pos <= is_last ? 4'd0 : r_pos + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && !i_status.empty) begin
            r_res <= res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_res;

endmodule

`default_nettype wire

>>> rtl/skl_checker.sv
// Port-level assertions for the SQL keyword lexer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module skl_checker import skl_pkg::*; (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     o_out_valid,
    input wire logic     i_out_stall,
    input wire t_out_req o_out_data
);

    // A stalled result request holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Text characters belong to an open string token.
    a_text_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_text |->
            o_out_data.token_code == TOK_STRING && !o_out_data.token_done &&
            !o_out_data.overflow)
        else $error("text character outside a string");

    // A token that is not a string is complete, ends its character and has no ordinal.
    a_plain_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.token_code != TOK_STRING |->
            o_out_data.token_done && o_out_data.last && o_out_data.string_pos == 8'd0)
        else $error("malformed plain token");

    // A dropped token carries no position.
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.overflow |->
            o_out_data.token_done && o_out_data.token_pos == 8'd0 &&
            o_out_data.string_pos == 8'd0)
        else $error("overflowed token with position");

endmodule

bind sql_keyword_lexer skl_checker u_skl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
